// ===== hw/rtl/brlm_pkg.sv =====
package brlm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int COUNT_W    = 13;
  localparam int MAX_BLOCK  = 4096;
  localparam int SQUARE_W   = 2 * SAMPLE_W;
  localparam int SUM_W      = 43;
  // mean of squares never exceeds the largest square, 2^30
  localparam int MEAN_W     = 31;
  localparam int DIV_STEPS  = SUM_W;
  localparam int ROOT_STEPS = (MEAN_W + 1) / 2;
  localparam int STEP_W     = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [COUNT_W-1:0] sample_count;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic accept;
    logic flush;
    logic div_step;
    logic root_load;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic root_last;
  } status_t;

endpackage

// ===== hw/rtl/block_rms_level_meter_unit.sv =====
// channel  direction  payload                               handshake
// in       input      in_data  {sample, is_last}            in_valid / in_stall
// out      output     out_data {rms_level, sample_count,    out_valid / out_stall
//                               overflow}
//
// One sample per cycle while a block accumulates (the square is registered, then added in the next cycle).
// A sample flagged is_last reaches a loaded result through a flush, 43 divider
// steps (one quotient bit each), a root load, 16 square-root steps and the output
// load.
// in_stall stays high from the last sample until the result enters the output
// register; a stalled result holds only that register and the next block accumulates.
// Reset (rst, synchronous) clears the accumulator, count, drop flag and controller.
module block_rms_level_meter_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  brlm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output brlm_pkg::out_t out_data
);

  brlm_pkg::cmd_t    cmd;
  brlm_pkg::status_t status;
  logic              in_last;

  // only a transfer flagged as last ends the block
  brlm_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  brlm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .in_last  (in_last),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/brlm_ctl.sv =====
module brlm_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output brlm_pkg::cmd_t    cmd,
  input  brlm_pkg::status_t status
);

  typedef enum logic [5:0] {
    ACCUM     = 6'b000001,
    FLUSH     = 6'b000010,
    DIVIDE    = 6'b000100,
    ROOT_LOAD = 6'b001000,
    ROOT      = 6'b010000,
    RESULT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != ACCUM);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.accept    = in_valid && !in_stall;
    unique case (state)
      ACCUM: begin
        // last sample of a block: fold in its square, then divide
        if (cmd.accept && in_last) begin
          state_next = FLUSH;
        end
      end
      FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = DIVIDE;
      end
      DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ROOT_LOAD;
        end
      end
      ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        state_next    = ROOT;
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = RESULT;
        end
      end
      RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ACCUM;
        end
      end
      default: state_next = ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/brlm_dp.sv =====
module brlm_dp (
  input  logic               clk,
  input  logic               rst,
  input  brlm_pkg::in_t      in_data,
  output logic               in_last,
  input  brlm_pkg::cmd_t     cmd,
  output brlm_pkg::status_t  status,
  output brlm_pkg::out_t     out_data
);

  // block accumulation
  logic [brlm_pkg::COUNT_W-1:0]  count;
  logic [brlm_pkg::COUNT_W-1:0]  count_next;
  logic                          drop;
  logic                          drop_next;
  logic                          full;
  logic [brlm_pkg::SAMPLE_W-1:0] raw;
  logic [brlm_pkg::SAMPLE_W-1:0] mag;
  logic [brlm_pkg::SQUARE_W-1:0] sq;
  logic                          sq_valid;
  logic [brlm_pkg::SUM_W-1:0]    sum;
  logic [brlm_pkg::SUM_W-1:0]    sum_total;

  // finished block
  logic [brlm_pkg::COUNT_W-1:0]  count_fin;
  logic                          drop_fin;

  // shift-subtract divider and digit-by-digit root
  logic [brlm_pkg::STEP_W-1:0]   step;
  logic [brlm_pkg::SUM_W-1:0]    dq;
  logic [brlm_pkg::COUNT_W-1:0]  rem;
  logic [brlm_pkg::COUNT_W:0]    rem_sh;
  logic [brlm_pkg::COUNT_W:0]    divisor;
  logic                          qbit;
  logic [brlm_pkg::MEAN_W-1:0]   rx;
  logic [brlm_pkg::MEAN_W-1:0]   root;
  logic [brlm_pkg::MEAN_W-1:0]   rbit;
  logic [brlm_pkg::MEAN_W-1:0]   trial;
  logic                          take;

  assign in_last = in_data.is_last;

  assign raw  = in_data.sample;
  assign mag  = raw[brlm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  assign full = (count == brlm_pkg::COUNT_W'(brlm_pkg::MAX_BLOCK));

  always_comb begin
    count_next = count;
    drop_next  = drop;
    if (full) begin
      drop_next = 1'b1;
    end else begin
      count_next = count + 1'b1;
    end
  end

  assign sum_total = sum + (sq_valid ? brlm_pkg::SUM_W'(sq) : '0);

  assign divisor = {1'b0, count_fin};
  assign rem_sh  = {rem, dq[brlm_pkg::SUM_W-1]};
  assign qbit    = (rem_sh >= divisor);

  assign trial = root + rbit;
  assign take  = (rx >= trial);

  assign status.div_last  = (step == brlm_pkg::STEP_W'(brlm_pkg::DIV_STEPS - 1));
  assign status.root_last = (step == brlm_pkg::STEP_W'(brlm_pkg::ROOT_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      drop     <= 1'b0;
      sq_valid <= 1'b0;
      sum      <= '0;
      step     <= '0;
    end else begin
      sq_valid <= cmd.accept && !full;
      if (cmd.accept) begin
        if (in_data.is_last) begin
          count <= '0;
          drop  <= 1'b0;
        end else begin
          count <= count_next;
          drop  <= drop_next;
        end
      end
      if (cmd.flush) begin
        sum <= '0;
      end else if (sq_valid) begin
        sum <= sum_total;
      end
      if (cmd.flush || cmd.root_load) begin
        step <= '0;
      end else if (cmd.div_step || cmd.root_step) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq <= brlm_pkg::SQUARE_W'(mag) * brlm_pkg::SQUARE_W'(mag);
      if (in_data.is_last) begin
        count_fin <= count_next;
        drop_fin  <= drop_next;
      end
    end
    if (cmd.flush) begin
      dq  <= sum_total;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[brlm_pkg::SUM_W-2:0], qbit};
      rem <= qbit ? brlm_pkg::COUNT_W'(rem_sh - divisor) : brlm_pkg::COUNT_W'(rem_sh);
    end
    if (cmd.root_load) begin
      rx   <= dq[brlm_pkg::MEAN_W-1:0];
      root <= '0;
      rbit <= brlm_pkg::MEAN_W'(1) << (brlm_pkg::MEAN_W - 1);
    end else if (cmd.root_step) begin
      if (take) begin
        rx   <= rx - trial;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.load_out) begin
      out_data.rms_level    <= root[brlm_pkg::LEVEL_W-1:0];
      out_data.sample_count <= count_fin;
      out_data.overflow     <= drop_fin;
    end
  end

endmodule

// ===== tb/tb_block_rms_level_meter_unit.sv =====
`timescale 1ns / 1ps

module tb_block_rms_level_meter_unit;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 100;

  // running sum of squares per block; one expected level per finished block
  class level_scoreboard;
    logic [brlm_pkg::SUM_W-1:0]   square_sum;
    logic [brlm_pkg::COUNT_W-1:0] block_count;
    logic                         dropped;
    brlm_pkg::out_t               levels_due[$];
    int                           errors;

    function new();
      square_sum  = '0;
      block_count = '0;
      dropped     = 1'b0;
      errors      = 0;
    endfunction

    function void note_sample(brlm_pkg::in_t d);
      logic [brlm_pkg::SAMPLE_W-1:0] raw;
      logic [brlm_pkg::SAMPLE_W-1:0] mag;
      logic [brlm_pkg::SUM_W-1:0]    mean;
      logic [brlm_pkg::LEVEL_W-1:0]  root;
      logic [brlm_pkg::LEVEL_W-1:0]  trial;
      brlm_pkg::out_t                level;
      raw = d.sample;
      mag = raw[brlm_pkg::SAMPLE_W-1] ? -raw : raw;
      if (block_count < brlm_pkg::MAX_BLOCK) begin
        square_sum  += brlm_pkg::SUM_W'(mag) * brlm_pkg::SUM_W'(mag);
        block_count += 1'b1;
      end else begin
        dropped = 1'b1;
      end
      if (!d.is_last) return;
      mean = (block_count != 0) ? square_sum / brlm_pkg::SUM_W'(block_count) : '0;
      // floor square root, one result bit per pass from the top
      root = '0;
      for (int b = brlm_pkg::LEVEL_W - 1; b >= 0; b--) begin
        trial = root | (brlm_pkg::LEVEL_W'(1) << b);
        if (64'(trial) * 64'(trial) <= 64'(mean)) root = trial;
      end
      level.rms_level    = root;
      level.sample_count = block_count;
      level.overflow     = dropped;
      levels_due.push_back(level);
      square_sum  = '0;
      block_count = '0;
      dropped     = 1'b0;
    endfunction

    function void check_level(brlm_pkg::out_t got);
      brlm_pkg::out_t want;
      if (levels_due.size() == 0) begin
        $error("unexpected result: rms_level %0d sample_count %0d overflow %0d",
               got.rms_level, got.sample_count, got.overflow);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      if (got.rms_level !== want.rms_level) begin
        $error("rms_level: expected %0d, actual %0d", want.rms_level, got.rms_level);
        errors++;
      end
      if (got.sample_count !== want.sample_count) begin
        $error("sample_count: expected %0d, actual %0d", want.sample_count, got.sample_count);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  brlm_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  brlm_pkg::out_t out_data;

  int in_idle_pct  = 18;
  int out_idle_pct = 66;
  int sent_items   = 0;
  int quiet_cycles = 0;

  level_scoreboard board = new();

  block_rms_level_meter_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_sample(in_data);
      if (out_valid && !out_stall) board.check_level(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_sample(logic [brlm_pkg::SAMPLE_W-1:0] value, logic last);
    brlm_pkg::in_t d;
    logic          took;
    d.sample  = value;
    d.is_last = last;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    // stall is settled by the falling edge, ahead of the edge that takes the transfer
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    sent_items++;
  endtask

  function automatic logic [brlm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_block(int len, bit full_scale);
    for (int i = 0; i < len; i++) begin
      send_sample(full_scale ? 16'h8000 : pick_sample(), i == len - 1);
    end
  endtask

  // hold off the sender until every expected level has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic random_blocks(int quota);
    int stop;
    stop = sent_items + quota;
    while (sent_items < stop) begin
      send_block(($urandom_range(9) == 0) ? $urandom_range(60, 9) : $urandom_range(6, 1), 1'b0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // one-sample blocks at the extremes
    send_sample(16'h0000, 1'b1);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    // mixed blocks, with alternating bit patterns
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0100, 1'b1);
    send_sample(16'h0003, 1'b0);
    send_sample(16'h0004, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    drain();

    // full-scale block, largest squares
    send_block(64, 1'b1);
    drain();

    random_blocks(600);
    drain();

    in_idle_pct  = 66;
    out_idle_pct = 18;
    random_blocks(600);
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_blocks(560);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
